FILE: hw/rtl/rpa_pkg.sv
// Shared types, codes and sizes for the rank pool allocator.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package rpa_pkg;

    localparam int MAX_RANKS = 256;
    localparam int RANK_W    = $clog2(MAX_RANKS);
    localparam int CNT_W     = $clog2(MAX_RANKS + 1);
    localparam int CFG_W     = 9;
    localparam int REQ_W     = 12;
    localparam int DPN_W     = 8;

    // Per-rank entry state codes.
    localparam logic [2:0] ST_UNREG  = 3'd0;
    localparam logic [2:0] ST_WORK_P = 3'd1;
    localparam logic [2:0] ST_WORK_S = 3'd2;
    localparam logic [2:0] ST_IDLE_P = 3'd3;
    localparam logic [2:0] ST_IDLE_S = 3'd4;

    localparam logic [2:0] CMD_REGISTER = 3'd0;
    localparam logic [2:0] CMD_REMOVE   = 3'd1;
    localparam logic [2:0] CMD_SET_IDLE = 3'd2;
    localparam logic [2:0] CMD_RSV_ANY  = 3'd3;
    localparam logic [2:0] CMD_RSV_GIV  = 3'd4;
    localparam logic [2:0] CMD_DEMAND   = 3'd5;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NO_FREE = 2'd1;
    localparam logic [1:0] STAT_INVALID = 2'd2;

    localparam logic [1:0] MODE_PRIMARY = 2'd0;
    localparam logic [1:0] MODE_ALSO    = 2'd1;
    localparam logic [1:0] MODE_NONE    = 2'd2;

    localparam logic [1:0] CFG_RPN  = 2'd0;
    localparam logic [1:0] CFG_PRPN = 2'd1;
    localparam logic [1:0] CFG_TOT  = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_RD_M,
        OP_RD_ADDR,
        OP_RD_UP,
        OP_RD_DN,
        OP_DIV_Q,
        OP_DIV_PRIM,
        OP_DIV_RPNM,
        OP_DIV_M1,
        OP_DIV_PN,
        OP_DIV_FIRST1,
        OP_DIV_FIRST2,
        OP_DIV_DEM,
        OP_REG,
        OP_REMOVE,
        OP_IDLE,
        OP_GRANT,
        OP_M0_INIT,
        OP_M0_NEXT,
        OP_FB_NEXT,
        OP_M1_INIT,
        OP_D_INC,
        OP_DEM1,
        OP_SET_M1,
        OP_DONE
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] status;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] cmd;
        logic [1:0] mode;
        logic [2:0] rd;
        logic       div_done;
        logic       m0_end;
        logic       fb_end;
        logic       up_ok;
        logic       dn_ok;
        logic       d_over;
        logic       dem_up;
        logic       clr_last;
    } t_dp_sts;

endpackage
`default_nettype wire

FILE: hw/rtl/rank_pool_allocator.sv
// Top level of the rank pool allocator: controller and datapath joined.
// Depends on rpa_pkg, rpa_ctrl, rpa_dp and rpa_div.
//
// Usage. One command enters on the input channel (i_in_valid / o_in_stall) and
// exactly one result leaves on the output channel (o_out_valid / i_out_stall).
// A transfer happens on a rising edge where valid is high and stall is low.
// The block works on one command at a time; o_in_stall is low only while the
// controller waits for a command.
// Latency depends on the command. Register and set idle make two divider
// passes for the primary test and then a table read. Remove and reserve
// given need no divider pass and read the table once. Reserve any in primary
// mode makes three divider passes and then probes one rank at a time, over
// up to nodes times deployed_per_node probes; if the node walk finds nothing,
// two more divider passes precede a fallback sweep of table_length ranks. In
// secondary mode it probes neighbors one at a time, outward up to total_ranks
// away from the rank. A demand that raises the mode needs no divider pass;
// one that resizes the per-node limit makes two divider passes. The
// single-port rank state memory and the serial divider set each latency.
// After reset a clearing pass writes every rank entry as unregistered, and no
// command is accepted during it; configuration writes are taken at any time
// but are meant for idle periods.
// A result that the receiver stalls sits in the output register; the next
// command is still accepted and worked on, and waits only for that register.
`default_nettype none
module rank_pool_allocator
    import rpa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [2:0]        i_command,
    input  wire logic [RANK_W-1:0] i_rank,
    input  wire logic [REQ_W-1:0]  i_requested_total,
    input  wire logic              i_queue_empty,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [1:0]             o_status,
    output logic [RANK_W-1:0]      o_granted_rank,
    output logic [1:0]             o_pool_mode,
    output logic                   o_has_idle,
    output logic [CNT_W-1:0]       o_idle_count,
    output logic [CNT_W-1:0]       o_idle_primary_count,
    output logic [CNT_W-1:0]       o_registered_count,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_idx,
    input  wire logic [CFG_W-1:0]  i_cfg_data
);

    // Commands flow from the controller to the datapath, status flows back.
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    rpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    rpa_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (dp_cmd),
        .o_sts                (dp_sts),
        .i_command            (i_command),
        .i_rank               (i_rank),
        .i_requested_total    (i_requested_total),
        .i_queue_empty        (i_queue_empty),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .o_status             (o_status),
        .o_granted_rank       (o_granted_rank),
        .o_pool_mode          (o_pool_mode),
        .o_has_idle           (o_has_idle),
        .o_idle_count         (o_idle_count),
        .o_idle_primary_count (o_idle_primary_count),
        .o_registered_count   (o_registered_count)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/rpa_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on rpa_pkg for operand widths.
`default_nettype none
module rpa_div
    import rpa_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [REQ_W-1:0] i_dividend,
    input  wire logic [CFG_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [REQ_W-1:0]      o_quot,
    output logic [CFG_W-1:0]      o_rem
);

    localparam int STEP_W = $clog2(REQ_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [REQ_W-1:0]  r_quot;
    logic [CFG_W-1:0]  r_rem;
    logic [CFG_W-1:0]  r_dvs;
    logic [CFG_W:0]    w_trial;
    logic              w_ge;

    assign w_trial = {r_rem, r_quot[REQ_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(REQ_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[REQ_W-2:0], w_ge};
            r_rem  <= w_ge ? CFG_W'(w_trial - {1'b0, r_dvs}) : w_trial[CFG_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

FILE: hw/rtl/rpa_dp.sv
// Datapath: rank state memory, configuration, counters, scan registers and results.
// Depends on rpa_pkg and rpa_div.
`default_nettype none
module rpa_dp
    import rpa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_sts                o_sts,
    input  wire logic [2:0]        i_command,
    input  wire logic [RANK_W-1:0] i_rank,
    input  wire logic [REQ_W-1:0]  i_requested_total,
    input  wire logic              i_queue_empty,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_idx,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    output logic [1:0]             o_status,
    output logic [RANK_W-1:0]      o_granted_rank,
    output logic [1:0]             o_pool_mode,
    output logic                   o_has_idle,
    output logic [CNT_W-1:0]       o_idle_count,
    output logic [CNT_W-1:0]       o_idle_primary_count,
    output logic [CNT_W-1:0]       o_registered_count
);

    logic [2:0] mem [MAX_RANKS];

    logic [CFG_W-1:0]  r_rpn, r_prpn, r_tot;
    logic [CFG_W-1:0]  rpn_c, prpn_c, tot_c;
    logic [2:0]        r_cmd;
    logic [RANK_W-1:0] r_m;
    logic [REQ_W-1:0]  r_req;
    logic              r_qe;
    logic [1:0]        r_mode;
    logic [DPN_W-1:0]  r_dpn;
    logic [CNT_W-1:0]  r_tlen;
    logic [CNT_W-1:0]  r_cnt_ip, r_cnt_is, r_cnt_reg;
    logic [2:0]        r_rd;
    logic [RANK_W-1:0] r_addr, r_base, r_rpnm, r_m1m, r_first, r_gnt, r_clr;
    logic [CFG_W-1:0]  r_q, r_pn, r_i, r_j, r_d;
    logic              r_prim;
    t_op               r_tgt;

    logic [1:0]        r_o_status;
    logic [RANK_W-1:0] r_o_gnt;
    logic [1:0]        r_o_mode;
    logic              r_o_has;
    logic [CNT_W-1:0]  r_o_idle, r_o_ip, r_o_reg;

    logic              div_start, div_done;
    logic [REQ_W-1:0]  div_nd, div_quot;
    logic [CFG_W-1:0]  div_dv, div_rem;
    logic [16:0]       w_prod;

    logic              wr_en, rd_en;
    logic [RANK_W-1:0] wr_addr, rd_addr;
    logic [2:0]        wr_data;
    logic [CFG_W-1:0]  w_inc, w_bnext;
    logic [RANK_W-1:0] w_addr_inc, w_base_nx;
    logic [CFG_W:0]    w_up;

    function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v);
        if (v == '0) return CFG_W'(1);
        if (v > CFG_W'(MAX_RANKS)) return CFG_W'(MAX_RANKS);
        return v;
    endfunction

    assign rpn_c  = clamp_cfg(r_rpn);
    assign prpn_c = clamp_cfg(r_prpn);
    assign tot_c  = clamp_cfg(r_tot);

    // Divider operand selection.
    always_comb begin
        div_start = 1'b1;
        div_nd    = '0;
        div_dv    = CFG_W'(1);
        unique case (i_cmd.op)
            OP_DIV_Q:      begin div_nd = REQ_W'(rpn_c);          div_dv = prpn_c; end
            OP_DIV_PRIM:   begin div_nd = REQ_W'(r_m);            div_dv = r_q;    end
            OP_DIV_RPNM:   begin div_nd = REQ_W'(rpn_c);          div_dv = tot_c;  end
            OP_DIV_M1:     begin div_nd = REQ_W'(r_m) + 1'b1;     div_dv = tot_c;  end
            OP_DIV_PN:     begin div_nd = REQ_W'(r_tlen);         div_dv = rpn_c;  end
            OP_DIV_FIRST1: begin div_nd = REQ_W'(r_m);            div_dv = rpn_c;  end
            OP_DIV_FIRST2: begin div_nd = REQ_W'(r_first);        div_dv = tot_c;  end
            OP_DIV_DEM:    begin div_nd = r_req;                  div_dv = r_pn;   end
            default:       div_start = 1'b0;
        endcase
    end

    rpa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_nd),
        .i_divisor  (div_dv),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    assign w_prod = 17'(div_quot[RANK_W-1:0]) * 17'(rpn_c);

    // Modular stepping of the scan addresses.
    assign w_inc      = CFG_W'(r_addr) + 1'b1;
    assign w_addr_inc = (w_inc >= tot_c) ? RANK_W'(w_inc - tot_c) : RANK_W'(w_inc);
    assign w_bnext    = CFG_W'(r_base) + CFG_W'(r_rpnm);
    assign w_base_nx  = (w_bnext >= tot_c) ? RANK_W'(w_bnext - tot_c) : RANK_W'(w_bnext);
    assign w_up       = (CFG_W+1)'(r_m) + (CFG_W+1)'(r_d);

    // Memory port selection.
    always_comb begin
        rd_en   = 1'b1;
        rd_addr = r_m;
        wr_en   = 1'b1;
        wr_addr = r_addr;
        wr_data = ST_UNREG;
        unique case (i_cmd.op)
            OP_RD_M:    rd_addr = r_m;
            OP_RD_ADDR: rd_addr = r_addr;
            OP_RD_UP:   rd_addr = RANK_W'(w_up);
            OP_RD_DN:   rd_addr = RANK_W'(CFG_W'(r_m) - r_d);
            default:    rd_en = 1'b0;
        endcase
        unique case (i_cmd.op)
            OP_CLEAR:  wr_addr = r_clr;
            OP_REG:    wr_data = r_prim ? ST_WORK_P : ST_WORK_S;
            OP_REMOVE: wr_data = ST_UNREG;
            OP_IDLE:   wr_data = (r_rd == ST_WORK_P) ? ST_IDLE_P : ST_IDLE_S;
            OP_GRANT:  wr_data = (r_rd == ST_IDLE_P) ? ST_WORK_P : ST_WORK_S;
            default:   wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) r_rd <= mem[rd_addr];
    end

    // Control-relevant state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rpn     <= CFG_W'(4);
            r_prpn    <= CFG_W'(4);
            r_tot     <= CFG_W'(MAX_RANKS);
            r_mode    <= MODE_PRIMARY;
            r_dpn     <= DPN_W'(4);
            r_tlen    <= '0;
            r_cnt_ip  <= '0;
            r_cnt_is  <= '0;
            r_cnt_reg <= '0;
            r_clr     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_RPN:  r_rpn <= i_cfg_data;
                    CFG_PRPN: begin
                        r_prpn <= i_cfg_data;
                        r_dpn  <= (clamp_cfg(i_cfg_data) > CFG_W'(255)) ? DPN_W'(255)
                                  : DPN_W'(clamp_cfg(i_cfg_data));
                    end
                    CFG_TOT:  r_tot <= i_cfg_data;
                    default:  ;
                endcase
            end
            if (i_cmd.op == OP_CLEAR) r_clr <= r_clr + 1'b1;
            if (wr_en && i_cmd.op != OP_CLEAR) begin
                r_cnt_ip  <= r_cnt_ip + CNT_W'(wr_data == ST_IDLE_P)
                             - CNT_W'(r_rd == ST_IDLE_P);
                r_cnt_is  <= r_cnt_is + CNT_W'(wr_data == ST_IDLE_S)
                             - CNT_W'(r_rd == ST_IDLE_S);
                r_cnt_reg <= r_cnt_reg + CNT_W'(wr_data != ST_UNREG)
                             - CNT_W'(r_rd != ST_UNREG);
            end
            if (i_cmd.op == OP_REG && r_tlen < CNT_W'(r_m) + 1'b1)
                r_tlen <= CNT_W'(r_m) + 1'b1;
            if (i_cmd.op == OP_IDLE) begin
                if (r_prim) r_mode <= MODE_PRIMARY;
                else if (r_mode == MODE_NONE) r_mode <= MODE_ALSO;
            end
            if (i_cmd.op == OP_DEM1 && r_qe && r_mode == MODE_ALSO) r_mode <= MODE_NONE;
            if (i_cmd.op == OP_SET_M1) r_mode <= MODE_ALSO;
            if (div_done && r_tgt == OP_DIV_DEM) begin
                if (div_quot == '0) r_dpn <= DPN_W'(1);
                else if (div_quot > REQ_W'(255)) r_dpn <= DPN_W'(255);
                else r_dpn <= div_quot[DPN_W-1:0];
            end
        end
    end

    // Working registers of one command.
    always_ff @(posedge i_clk) begin
        if (div_start) r_tgt <= i_cmd.op;
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_cmd <= i_command;
                r_m   <= i_rank;
                r_req <= i_requested_total;
                r_qe  <= i_queue_empty;
                r_gnt <= '0;
            end
            OP_RD_M:    r_addr <= r_m;
            OP_RD_UP:   r_addr <= RANK_W'(w_up);
            OP_RD_DN:   r_addr <= RANK_W'(CFG_W'(r_m) - r_d);
            OP_GRANT:   r_gnt  <= r_addr;
            OP_M0_INIT: begin
                r_base <= r_m1m;
                r_addr <= r_m1m;
                r_i    <= '0;
                r_j    <= '0;
            end
            OP_M0_NEXT: begin
                if (r_i + 1'b1 < CFG_W'(r_dpn)) begin
                    r_i    <= r_i + 1'b1;
                    r_addr <= w_addr_inc;
                end else begin
                    r_i    <= '0;
                    r_j    <= r_j + 1'b1;
                    r_base <= w_base_nx;
                    r_addr <= w_base_nx;
                end
            end
            OP_FB_NEXT: begin
                r_i    <= r_i + 1'b1;
                r_addr <= w_addr_inc;
            end
            OP_M1_INIT: r_d <= CFG_W'(1);
            OP_D_INC:   r_d <= r_d + 1'b1;
            default: ;
        endcase
        if (div_done) begin
            unique case (r_tgt)
                OP_DIV_Q:      r_q    <= (div_quot == '0) ? CFG_W'(1) : div_quot[CFG_W-1:0];
                OP_DIV_PRIM:   r_prim <= (div_rem == '0);
                OP_DIV_RPNM:   r_rpnm <= div_rem[RANK_W-1:0];
                OP_DIV_M1:     r_m1m  <= div_rem[RANK_W-1:0];
                OP_DIV_PN:     r_pn   <= (div_quot == '0) ? CFG_W'(1) : div_quot[CFG_W-1:0];
                OP_DIV_FIRST1: r_first <= w_prod[RANK_W-1:0];
                OP_DIV_FIRST2: begin
                    r_addr <= div_rem[RANK_W-1:0];
                    r_i    <= '0;
                end
                default: ;
            endcase
        end
        if (i_cmd.op == OP_DONE) begin
            r_o_status <= i_cmd.status;
            r_o_gnt    <= r_gnt;
            r_o_mode   <= r_mode;
            r_o_has    <= (r_mode == MODE_PRIMARY) ? (r_cnt_ip != '0)
                        : (r_mode == MODE_ALSO) ? ((r_cnt_ip + r_cnt_is) != '0) : 1'b0;
            r_o_idle   <= r_cnt_ip + r_cnt_is;
            r_o_ip     <= r_cnt_ip;
            r_o_reg    <= r_cnt_reg;
        end
    end

    always_comb begin
        o_sts.cmd      = r_cmd;
        o_sts.mode     = r_mode;
        o_sts.rd       = r_rd;
        o_sts.div_done = div_done;
        o_sts.m0_end   = r_j >= r_pn;
        o_sts.fb_end   = r_i >= r_tlen;
        o_sts.up_ok    = w_up < (CFG_W+1)'(tot_c);
        o_sts.dn_ok    = r_d <= CFG_W'(r_m);
        o_sts.d_over   = r_d > tot_c;
        o_sts.dem_up   = (r_req > REQ_W'(r_cnt_ip)) && (r_mode != MODE_NONE);
        o_sts.clr_last = r_clr == RANK_W'(MAX_RANKS - 1);
    end

    assign o_status             = r_o_status;
    assign o_granted_rank       = r_o_gnt;
    assign o_pool_mode          = r_o_mode;
    assign o_has_idle           = r_o_has;
    assign o_idle_count         = r_o_idle;
    assign o_idle_primary_count = r_o_ip;
    assign o_registered_count   = r_o_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/rpa_ctrl.sv
// Controller state machine: sequences each command over the datapath.
// Depends on rpa_pkg for the command and status structs.
`default_nettype none
module rpa_ctrl
    import rpa_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_DISP, S_DIVW, S_PRIM, S_RD, S_CK,
        S_M1M, S_PN, S_M0I, S_M0P, S_M0C, S_FB1, S_FB2, S_FBP, S_FBC,
        S_UP, S_UPC, S_DN, S_DNC, S_DEM, S_DEMD, S_FIN
    } t_state;

    t_state     r_state, n_state, r_after, n_after;
    logic [1:0] r_stat, n_stat;
    logic       r_ovalid;
    t_op        op;
    logic       rd_idle;

    assign rd_idle = (i_sts.rd == ST_IDLE_P) || (i_sts.rd == ST_IDLE_S);

    always_comb begin
        n_state = r_state;
        n_after = r_after;
        n_stat  = r_stat;
        op      = OP_NONE;
        unique case (r_state)
            S_CLR: begin
                op = OP_CLEAR;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    op      = OP_LOAD;
                    n_stat  = STAT_OK;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_sts.cmd)
                    CMD_REGISTER, CMD_SET_IDLE: begin
                        op = OP_DIV_Q; n_after = S_PRIM; n_state = S_DIVW;
                    end
                    CMD_REMOVE, CMD_RSV_GIV: n_state = S_RD;
                    CMD_RSV_ANY: begin
                        if (i_sts.mode == MODE_PRIMARY) begin
                            op = OP_DIV_RPNM; n_after = S_M1M; n_state = S_DIVW;
                        end else if (i_sts.mode == MODE_ALSO) begin
                            n_state = S_RD;
                        end else begin
                            n_stat = STAT_NO_FREE; n_state = S_FIN;
                        end
                    end
                    CMD_DEMAND: begin
                        op = OP_DEM1; n_state = S_DEM;
                    end
                    default: begin
                        n_stat = STAT_INVALID; n_state = S_FIN;
                    end
                endcase
            end
            S_DIVW: if (i_sts.div_done) n_state = r_after;
            S_PRIM: begin
                op = OP_DIV_PRIM; n_after = S_RD; n_state = S_DIVW;
            end
            S_RD: begin
                op = OP_RD_M; n_state = S_CK;
            end
            S_CK: begin
                n_state = S_FIN;
                unique case (i_sts.cmd)
                    CMD_REGISTER: op = OP_REG;
                    CMD_REMOVE: begin
                        if (i_sts.rd == ST_UNREG) n_stat = STAT_INVALID;
                        else op = OP_REMOVE;
                    end
                    CMD_SET_IDLE: begin
                        if (i_sts.rd == ST_WORK_P || i_sts.rd == ST_WORK_S) op = OP_IDLE;
                        else n_stat = STAT_INVALID;
                    end
                    CMD_RSV_GIV: begin
                        if (rd_idle) op = OP_GRANT;
                        else n_stat = STAT_INVALID;
                    end
                    CMD_RSV_ANY: begin
                        if (rd_idle) n_stat = STAT_INVALID;
                        else begin
                            op = OP_M1_INIT; n_state = S_UP;
                        end
                    end
                    default: n_stat = STAT_INVALID;
                endcase
            end
            S_M1M: begin
                op = OP_DIV_M1; n_after = S_PN; n_state = S_DIVW;
            end
            S_PN: begin
                op = OP_DIV_PN; n_after = S_M0I; n_state = S_DIVW;
            end
            S_M0I: begin
                op = OP_M0_INIT; n_state = S_M0P;
            end
            S_M0P: begin
                if (i_sts.m0_end) n_state = S_FB1;
                else begin
                    op = OP_RD_ADDR; n_state = S_M0C;
                end
            end
            S_M0C: begin
                if (i_sts.rd == ST_IDLE_P) begin
                    op = OP_GRANT; n_state = S_FIN;
                end else begin
                    op = OP_M0_NEXT; n_state = S_M0P;
                end
            end
            S_FB1: begin
                op = OP_DIV_FIRST1; n_after = S_FB2; n_state = S_DIVW;
            end
            S_FB2: begin
                op = OP_DIV_FIRST2; n_after = S_FBP; n_state = S_DIVW;
            end
            S_FBP: begin
                if (i_sts.fb_end) begin
                    n_stat = STAT_NO_FREE; n_state = S_FIN;
                end else begin
                    op = OP_RD_ADDR; n_state = S_FBC;
                end
            end
            S_FBC: begin
                if (i_sts.rd == ST_IDLE_P) begin
                    op = OP_GRANT; n_state = S_FIN;
                end else begin
                    op = OP_FB_NEXT; n_state = S_FBP;
                end
            end
            S_UP: begin
                if (i_sts.d_over) begin
                    n_stat = STAT_NO_FREE; n_state = S_FIN;
                end else if (i_sts.up_ok) begin
                    op = OP_RD_UP; n_state = S_UPC;
                end else n_state = S_DN;
            end
            S_UPC: begin
                if (rd_idle) begin
                    op = OP_GRANT; n_state = S_FIN;
                end else n_state = S_DN;
            end
            S_DN: begin
                if (i_sts.dn_ok) begin
                    op = OP_RD_DN; n_state = S_DNC;
                end else begin
                    op = OP_D_INC; n_state = S_UP;
                end
            end
            S_DNC: begin
                if (rd_idle) begin
                    op = OP_GRANT; n_state = S_FIN;
                end else begin
                    op = OP_D_INC; n_state = S_UP;
                end
            end
            S_DEM: begin
                if (i_sts.dem_up) begin
                    op = OP_SET_M1; n_state = S_FIN;
                end else begin
                    op = OP_DIV_PN; n_after = S_DEMD; n_state = S_DIVW;
                end
            end
            S_DEMD: begin
                op = OP_DIV_DEM; n_after = S_FIN; n_state = S_DIVW;
            end
            S_FIN: begin
                if (!r_ovalid || !i_out_stall) begin
                    op = OP_DONE; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_after  <= S_IDLE;
            r_stat   <= STAT_OK;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_stat  <= n_stat;
            if (op == OP_DONE) r_ovalid <= 1'b1;
            else if (!i_out_stall) r_ovalid <= 1'b0;
        end
    end

    assign o_cmd.op     = op;
    assign o_cmd.status = r_stat;
    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_ovalid;

endmodule
`default_nettype wire

FILE: hw/rtl/rpa_chk.sv
// Port-level checker for the rank pool allocator and its bind to the top level.
// Depends on rpa_pkg and on rank_pool_allocator.
`default_nettype none
module rpa_chk
    import rpa_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire logic [1:0]        o_status,
    input wire logic [RANK_W-1:0] o_granted_rank,
    input wire logic [1:0]        o_pool_mode,
    input wire logic              o_has_idle,
    input wire logic [CNT_W-1:0]  o_idle_count,
    input wire logic [CNT_W-1:0]  o_idle_primary_count,
    input wire logic [CNT_W-1:0]  o_registered_count
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_granted_rank) && $stable(o_status))
        else $error("stalled result changed");

    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != STAT_OK |-> o_granted_rank == '0)
        else $error("grant on failed command");

    a_count_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_idle_primary_count <= o_idle_count
                        && o_idle_count <= o_registered_count)
        else $error("counts inconsistent");

    a_none_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_pool_mode == MODE_NONE |-> !o_has_idle)
        else $error("idle reported with no pool left");

endmodule

bind rank_pool_allocator rpa_chk u_rpa_chk (.*);
`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for rank_pool_allocator: a queue-fed driver, a
// monitor with a built-in prediction of the rank pool, and phased register settings.
// Depends on rpa_pkg and the rank_pool_allocator RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import rpa_pkg::*;

    // Command codes that the block does not define.
    localparam logic [2:0] CMD_BAD_LO = 3'd6;
    localparam logic [2:0] CMD_BAD_HI = 3'd7;

    // One command as it enters the block.
    typedef struct {
        logic [2:0]       cmd;
        logic [RANK_W-1:0] rank;
        logic [REQ_W-1:0] req;
        logic             qempty;
    } t_pool_cmd;

    // One result as the block should report it.
    typedef struct {
        logic [1:0]        status;
        logic [RANK_W-1:0] granted;
        logic [1:0]        mode;
        logic              has_idle;
        logic [CNT_W-1:0]  idle_all;
        logic [CNT_W-1:0]  idle_prim;
        logic [CNT_W-1:0]  regd;
    } t_pool_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   o_in_stall;
    logic [2:0]             in_cmd = '0;
    logic [RANK_W-1:0]      in_rank = '0;
    logic [REQ_W-1:0]       in_req = '0;
    logic                   in_qempty = 1'b0;
    logic                   o_out_valid;
    logic                   out_stall = 1'b0;
    logic [1:0]             o_status;
    logic [RANK_W-1:0]      o_granted_rank;
    logic [1:0]             o_pool_mode;
    logic                   o_has_idle;
    logic [CNT_W-1:0]       o_idle_count;
    logic [CNT_W-1:0]       o_idle_primary_count;
    logic [CNT_W-1:0]       o_registered_count;
    logic                   cfg_we = 1'b0;
    logic [1:0]             cfg_idx = '0;
    logic [CFG_W-1:0]       cfg_data = '0;

    rank_pool_allocator dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (in_valid),
        .o_in_stall           (o_in_stall),
        .i_command            (in_cmd),
        .i_rank               (in_rank),
        .i_requested_total    (in_req),
        .i_queue_empty        (in_qempty),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (out_stall),
        .o_status             (o_status),
        .o_granted_rank       (o_granted_rank),
        .o_pool_mode          (o_pool_mode),
        .o_has_idle           (o_has_idle),
        .o_idle_count         (o_idle_count),
        .o_idle_primary_count (o_idle_primary_count),
        .o_registered_count   (o_registered_count),
        .i_cfg_we             (cfg_we),
        .i_cfg_idx            (cfg_idx),
        .i_cfg_data           (cfg_data)
    );

    // Clock with a 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predicted copy of the pool: register values, per-rank states, mode,
    // the per-node deployment limit and the table length.
    logic [CFG_W-1:0] rpn_reg, prpn_reg, tot_reg;
    logic [2:0]       rank_state [MAX_RANKS];
    logic [1:0]       pool_mode;
    int               deploy_limit;
    int               table_len;

    t_pool_cmd        cmd_q [$];
    t_pool_result     result_q [$];
    t_pool_cmd        held;
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    int               error_count = 0;
    int               transfers_in = 0;
    int               transfers_out = 0;
    int               pushed = 0;
    int               grants_seen = 0;
    longint           cycle_count = 0;

    function automatic int clamp9(logic [CFG_W-1:0] v);
        if (v < 1) return 1;
        if (v > 256) return 256;
        return int'(v);
    endfunction

    // A rank is primary when it falls on a multiple of the ratio of ranks
    // per node to primary ranks per node; a zero ratio counts as one.
    function automatic bit rank_is_primary(int r);
        int q;
        q = clamp9(rpn_reg) / clamp9(prpn_reg);
        if (q == 0) q = 1;
        return (r % q) == 0;
    endfunction

    // Entries at or beyond the table length are seen as unregistered by scans.
    function automatic logic [2:0] table_slot(int r);
        if (r >= table_len || r >= MAX_RANKS) return ST_UNREG;
        return rank_state[r];
    endfunction

    function automatic bit slot_idle(int r);
        logic [2:0] s;
        s = table_slot(r);
        return s == ST_IDLE_P || s == ST_IDLE_S;
    endfunction

    function automatic void make_working(int r);
        rank_state[r] = (rank_state[r] == ST_IDLE_P) ? ST_WORK_P : ST_WORK_S;
    endfunction

    function automatic int node_count();
        int n;
        n = table_len / clamp9(rpn_reg);
        return n < 1 ? 1 : n;
    endfunction

    function automatic int count_states(logic [2:0] a, logic [2:0] b);
        int n;
        n = 0;
        for (int r = 0; r < MAX_RANKS; r++)
            if (rank_state[r] == a || rank_state[r] == b) n++;
        return n;
    endfunction

    // Reservation on behalf of master m. Primary mode walks the nodes within
    // the deployment limit and then sweeps from the master's node; secondary
    // mode searches outward from the master, capped at total_ranks distance.
    function automatic logic [1:0] reserve_for_master(int m, output int g);
        int rpn, tot, r, first;
        rpn = clamp9(rpn_reg);
        tot = clamp9(tot_reg);
        g = 0;
        if (pool_mode == MODE_PRIMARY) begin
            for (int j = 0; j < node_count(); j++)
                for (int i = 0; i < deploy_limit; i++) begin
                    r = (j * rpn + i + m + 1) % tot;
                    if (table_slot(r) == ST_IDLE_P) begin
                        make_working(r);
                        g = r;
                        return STAT_OK;
                    end
                end
            first = (m / rpn) * rpn;
            for (int i = 0; i < table_len; i++) begin
                r = (first + i) % tot;
                if (table_slot(r) == ST_IDLE_P) begin
                    make_working(r);
                    g = r;
                    return STAT_OK;
                end
            end
            return STAT_NO_FREE;
        end
        if (pool_mode == MODE_ALSO) begin
            if (slot_idle(m)) return STAT_INVALID;
            for (int i = 1; i <= tot; i++) begin
                if (m + i < tot && slot_idle(m + i)) begin
                    make_working(m + i);
                    g = m + i;
                    return STAT_OK;
                end
                if (i <= m && slot_idle(m - i)) begin
                    make_working(m - i);
                    g = m - i;
                    return STAT_OK;
                end
            end
        end
        return STAT_NO_FREE;
    endfunction

    // Apply one accepted command to the predicted pool and queue its result.
    function automatic void pool_apply(t_pool_cmd c);
        t_pool_result res;
        int           r, g, d, idle_p, idle_a;
        logic [2:0]   s;
        r = int'(c.rank);
        res.status = STAT_OK;
        res.granted = '0;
        case (c.cmd)
            CMD_REGISTER: begin
                rank_state[r] = rank_is_primary(r) ? ST_WORK_P : ST_WORK_S;
                if (table_len < r + 1) table_len = r + 1;
            end
            CMD_REMOVE: begin
                if (table_slot(r) == ST_UNREG) res.status = STAT_INVALID;
                else rank_state[r] = ST_UNREG;
            end
            CMD_SET_IDLE: begin
                s = table_slot(r);
                if (s != ST_WORK_P && s != ST_WORK_S) begin
                    res.status = STAT_INVALID;
                end else begin
                    rank_state[r] = (s == ST_WORK_P) ? ST_IDLE_P : ST_IDLE_S;
                    if (rank_is_primary(r)) pool_mode = MODE_PRIMARY;
                    else if (pool_mode == MODE_NONE) pool_mode = MODE_ALSO;
                end
            end
            CMD_RSV_ANY: begin
                res.status = reserve_for_master(r, g);
                if (res.status == STAT_OK) res.granted = g[RANK_W-1:0];
            end
            CMD_RSV_GIV: begin
                if (!slot_idle(r)) begin
                    res.status = STAT_INVALID;
                end else begin
                    make_working(r);
                    res.granted = c.rank;
                end
            end
            CMD_DEMAND: begin
                if (c.qempty && pool_mode == MODE_ALSO) pool_mode = MODE_NONE;
                if (int'(c.req) > count_states(ST_IDLE_P, ST_IDLE_P)
                        && pool_mode != MODE_NONE) begin
                    pool_mode = MODE_ALSO;
                end else begin
                    d = int'(c.req) / node_count();
                    if (d < 1) d = 1;
                    if (d > 255) d = 255;
                    deploy_limit = d;
                end
            end
            default: res.status = STAT_INVALID;
        endcase
        idle_p = count_states(ST_IDLE_P, ST_IDLE_P);
        idle_a = count_states(ST_IDLE_P, ST_IDLE_S);
        res.mode = pool_mode;
        res.has_idle = (pool_mode == MODE_PRIMARY) ? (idle_p != 0) :
                       (pool_mode == MODE_ALSO) ? (idle_a != 0) : 1'b0;
        res.idle_all = idle_a[CNT_W-1:0];
        res.idle_prim = idle_p[CNT_W-1:0];
        res.regd = CNT_W'(MAX_RANKS - count_states(ST_UNREG, ST_UNREG));
        result_q = {result_q, res};
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        error_count++;
        $display("MISMATCH at cycle %0d, transfer %0d: %s is %0d, expected %0d",
                 cycle_count, transfers_out, what, got, want);
    endtask

    // Driver: a command is taken from the queue whenever the channel is free,
    // unless the sender decides to idle this cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                pool_apply(held);
                transfers_in++;
            end
            if (!in_valid || !o_in_stall) begin
                if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    held = cmd_q.pop_front();
                    in_cmd <= held.cmd;
                    in_rank <= held.rank;
                    in_req <= held.req;
                    in_qempty <= held.qempty;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transfer against the oldest prediction and
    // stalls the output channel at random.
    always @(posedge i_clk) begin
        t_pool_result want;
        cycle_count++;
        if (i_rst_n && o_out_valid && !out_stall) begin
            transfers_out++;
            if (result_q.size() == 0) begin
                report_mismatch("result transfers", transfers_out, transfers_in);
            end else begin
                want = result_q.pop_front();
                if (o_status != want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_granted_rank != want.granted)
                    report_mismatch("granted_rank", o_granted_rank, want.granted);
                if (o_pool_mode != want.mode)
                    report_mismatch("pool_mode", o_pool_mode, want.mode);
                if (o_has_idle != want.has_idle)
                    report_mismatch("has_idle", o_has_idle, want.has_idle);
                if (o_idle_count != want.idle_all)
                    report_mismatch("idle_count", o_idle_count, want.idle_all);
                if (o_idle_primary_count != want.idle_prim)
                    report_mismatch("idle_primary_count", o_idle_primary_count,
                                    want.idle_prim);
                if (o_registered_count != want.regd)
                    report_mismatch("registered_count", o_registered_count, want.regd);
                if (want.status == STAT_OK && (want.granted != 0 || o_granted_rank != 0))
                    grants_seen++;
            end
        end
        out_stall <= ($urandom_range(99) < recv_idle_pct);
        if (cycle_count > 50000000) begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     cycle_count, result_q.size());
            $display("rank_pool_allocator verification failed");
            $finish;
        end
    end

    // Register write at a rising edge; the prediction takes the new value too.
    // Writing the primary ratio also reloads the deployment limit. The caller
    // drops the write enable after its last write.
    task automatic write_register(logic [1:0] idx, logic [CFG_W-1:0] val);
        int d;
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_RPN: rpn_reg = val;
            CFG_PRPN: begin
                prpn_reg = val;
                d = clamp9(val);
                deploy_limit = d > 255 ? 255 : d;
            end
            CFG_TOT: tot_reg = val;
            default: ;
        endcase
    endtask

    function automatic void push_cmd(logic [2:0] c, int r, int req, bit qe);
        t_pool_cmd item;
        item.cmd = c;
        item.rank = r[RANK_W-1:0];
        item.req = req[REQ_W-1:0];
        item.qempty = qe;
        cmd_q = {cmd_q, item};
        pushed++;
    endfunction

    // Random traffic: mostly ranks from a small working set so that register,
    // idle and reserve sequences meet each other; now and then any rank,
    // a large demand or an undefined command code.
    function automatic void push_random(int n);
        int pick, r, req;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            r = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(23);
            req = ($urandom_range(7) == 0) ? $urandom_range(4095) : $urandom_range(12);
            if (pick < 20)      push_cmd(CMD_REGISTER, r, $urandom_range(4095), $urandom_range(1));
            else if (pick < 45) push_cmd(CMD_SET_IDLE, r, $urandom_range(4095), $urandom_range(1));
            else if (pick < 65) push_cmd(CMD_RSV_ANY, r, $urandom_range(4095), $urandom_range(1));
            else if (pick < 75) push_cmd(CMD_RSV_GIV, r, $urandom_range(4095), $urandom_range(1));
            else if (pick < 85) push_cmd(CMD_REMOVE, r, $urandom_range(4095), $urandom_range(1));
            else if (pick < 97) push_cmd(CMD_DEMAND, r, req, $urandom_range(1));
            else                push_cmd($urandom_range(1) ? CMD_BAD_LO : CMD_BAD_HI,
                                         r, req, 1'b0);
        end
    endfunction

    // Wait until every queued command has produced its result transfer,
    // then a short pause so that the block is settled.
    task automatic drain();
        while (transfers_out < pushed) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Register settings per phase: ranks per node, primary ranks per node and
    // total ranks, including out-of-range values that the block clamps.
    logic [CFG_W-1:0] phase_cfg [7][3] = '{
        '{9'd4,   9'd4,   9'd256},
        '{9'd8,   9'd2,   9'd256},
        '{9'd1,   9'd1,   9'd1},
        '{9'd256, 9'd1,   9'd64},
        '{9'd0,   9'd511, 9'd300},
        '{9'd3,   9'd2,   9'd200},
        '{9'd511, 9'd0,   9'd0}
    };

    initial begin
        rpn_reg = 9'd4;
        prpn_reg = 9'd4;
        tot_reg = 9'd256;
        foreach (rank_state[r]) rank_state[r] = ST_UNREG;
        pool_mode = MODE_PRIMARY;
        deploy_limit = 4;
        table_len = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: ranks at both ends, every command, idle and
        // reserve misuse, both demand outcomes and undefined command codes.
        push_cmd(CMD_REMOVE, 5, 0, 0);
        push_cmd(CMD_REGISTER, 0, 0, 0);
        push_cmd(CMD_REGISTER, 1, 0, 0);
        push_cmd(CMD_REGISTER, 4, 0, 0);
        push_cmd(CMD_REGISTER, 255, 4095, 1);
        push_cmd(CMD_SET_IDLE, 3, 0, 0);
        push_cmd(CMD_RSV_ANY, 0, 0, 0);
        push_cmd(CMD_SET_IDLE, 4, 0, 0);
        push_cmd(CMD_SET_IDLE, 4, 0, 0);
        push_cmd(CMD_RSV_ANY, 0, 0, 0);
        push_cmd(CMD_SET_IDLE, 1, 0, 0);
        push_cmd(CMD_DEMAND, 0, 4095, 0);
        push_cmd(CMD_RSV_ANY, 1, 0, 0);
        push_cmd(CMD_RSV_ANY, 0, 0, 0);
        push_cmd(CMD_SET_IDLE, 255, 0, 0);
        push_cmd(CMD_DEMAND, 0, 4095, 1);
        push_cmd(CMD_RSV_ANY, 7, 0, 0);
        push_cmd(CMD_SET_IDLE, 1, 0, 0);
        push_cmd(CMD_RSV_GIV, 255, 0, 0);
        push_cmd(CMD_RSV_GIV, 255, 0, 0);
        push_cmd(CMD_DEMAND, 255, 0, 0);
        push_cmd(CMD_REMOVE, 255, 0, 0);
        push_cmd(CMD_BAD_LO, 0, 0, 0);
        push_cmd(CMD_BAD_HI, 255, 4095, 1);
        drain();

        for (int ph = 0; ph < 7; ph++) begin
            // Sender mostly busy first, then the receiver, then no idling.
            case (ph * 3 / 7)
                0: begin send_idle_pct = 8;  recv_idle_pct = 77; end
                1: begin send_idle_pct = 77; recv_idle_pct = 8;  end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            if (ph > 0) begin
                write_register(CFG_RPN, phase_cfg[ph][0]);
                write_register(CFG_PRPN, phase_cfg[ph][1]);
                write_register(CFG_TOT, phase_cfg[ph][2]);
                cfg_we <= 1'b0;
            end
            push_random(150);
            drain();
        end

        $display("Covered %0d command transfers and %0d result transfers with %0d grants,",
                 transfers_in, transfers_out, grants_seen);
        $display("over seven register settings and three idling regimes; %0d mismatches.",
                 error_count);
        if (error_count == 0 && result_q.size() == 0) begin
            $display("rank_pool_allocator verification clean");
        end else begin
            $display("rank_pool_allocator verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
